// ----- src/rrs_pkg.sv -----
// Package with the shared types, codes and sizes of the round-robin scheduler.
`default_nettype none
package rrs_pkg;

  // Number of entries in the ready queue.
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned ID_W    = 8;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned QCNT_W  = 5;

  // Input action codes.
  localparam logic ACT_ADD      = 1'b0;
  localparam logic ACT_DISPATCH = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // One entry of the ready queue.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] need;
    logic [TIME_W-1:0] run;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  // One result transaction.
  typedef struct packed {
    logic [ID_W-1:0]   served_id;
    logic [TIME_W-1:0] run_time;
    logic              finished;
    logic [STAT_W-1:0] status;
    logic [QCNT_W-1:0] queue_count;
  } result_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

endpackage
`default_nettype wire

// ----- src/round_robin_time_slice_scheduler.sv -----
// Top level of the round-robin time-slice scheduler with its queue controller.
// Usage:
// The input channel (in_valid_i, in_stall_o) carries requests: an add appends
// a task with zero run time at the tail of the ready queue, a dispatch pops the
// head, adds the quantum to its run time and either retires it or appends it
// again at the tail. Each request gives exactly one result transaction on the
// output channel (out_valid_o, out_stall_i), in request order.
// The ready queue lives in a synchronous RAM with a registered read port.
// An add, a full add and an empty dispatch are answered in the cycle of
// acceptance and their result is registered in the output stage. A dispatch
// of a waiting task first reads the head entry and then updates it and writes
// it back, and its result is registered in the output stage.
// The quantum register is written through cfg_we_i and cfg_data_i; the user
// must write it only while the block is idle; the block does not enforce it.
// Reset sets it to one, empties the queue (head, tail and count return to zero)
// and clears the valid flags of both output stages; RAM contents are not cleared.
// When the receiver stalls, one more result is held in a skid stage, after
// which requests are stalled until the skid stage drains.
`default_nettype none
module round_robin_time_slice_scheduler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  task_id_i,
  input  wire logic [15:0] need_time_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       served_id_o,
  output logic [15:0]      run_time_o,
  output logic             finished_o,
  output logic [1:0]       status_o,
  output logic [4:0]       queue_count_o
);

  localparam logic [rrs_pkg::IDX_W-1:0] LAST_IDX = rrs_pkg::IDX_W'(rrs_pkg::QUEUE_DEPTH - 1);
  localparam logic [rrs_pkg::CNT_W-1:0] FULL_CNT = rrs_pkg::CNT_W'(rrs_pkg::QUEUE_DEPTH);

  rrs_pkg::state_e               state_q, state_d;
  logic [rrs_pkg::IDX_W-1:0]     head_q, head_d;
  logic [rrs_pkg::IDX_W-1:0]     tail_q, tail_d;
  logic [rrs_pkg::CNT_W-1:0]     count_q, count_d;
  logic [rrs_pkg::TIME_W-1:0]    quantum_q;

  logic                          skid_full;
  logic                          in_accept;
  logic                          ram_we;
  rrs_pkg::slot_t                ram_wdata;
  rrs_pkg::slot_t                ram_rdata;
  logic                          res_valid;
  rrs_pkg::result_t              res;
  rrs_pkg::result_t              out_res;

  logic [rrs_pkg::TIME_W:0]      run_sum;
  logic [rrs_pkg::TIME_W-1:0]    run_sat;
  logic                          done;

  // Wrapping increment of a queue index.
  function automatic logic [rrs_pkg::IDX_W-1:0] next_pos(
    input logic [rrs_pkg::IDX_W-1:0] idx
  );
    next_pos = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  // Requests are taken only between dispatches and while the skid stage is free.
  assign in_stall_o = (state_q != rrs_pkg::ST_IDLE) || skid_full;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Slice arithmetic on the entry read from the head, saturating at the top.
  assign run_sum = {1'b0, ram_rdata.run} + {1'b0, quantum_q};
  assign run_sat = run_sum[rrs_pkg::TIME_W] ? '1 : run_sum[rrs_pkg::TIME_W-1:0];
  assign done    = run_sat >= ram_rdata.need;

  // Quantum configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= rrs_pkg::TIME_W'(1);
    end else if (cfg_we_i) begin
      quantum_q <= cfg_data_i;
    end
  end

  // Controller and queue pointer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrs_pkg::ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Next state, pointer updates, RAM write and result generation.
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    ram_we    = 1'b0;
    ram_wdata = '{id: task_id_i, need: need_time_i, run: '0};
    res_valid = 1'b0;
    res       = '{served_id: '0, run_time: '0, finished: 1'b0,
                  status: rrs_pkg::STAT_OK, queue_count: rrs_pkg::QCNT_W'(count_q)};
    unique case (state_q)
      rrs_pkg::ST_IDLE: begin
        if (in_accept) begin
          priority if (action_i == rrs_pkg::ACT_ADD && count_q == FULL_CNT) begin
            res_valid  = 1'b1;
            res.status = rrs_pkg::STAT_FULL;
          end else if (action_i == rrs_pkg::ACT_ADD) begin
            ram_we            = 1'b1;
            tail_d            = next_pos(tail_q);
            count_d           = count_q + 1'b1;
            res_valid         = 1'b1;
            res.served_id     = task_id_i;
            res.queue_count   = rrs_pkg::QCNT_W'(count_q + 1'b1);
          end else if (count_q == '0) begin
            res_valid  = 1'b1;
            res.status = rrs_pkg::STAT_EMPTY;
          end else begin
            // Head entry is read at this edge; it is finished next cycle.
            head_d  = next_pos(head_q);
            count_d = count_q - 1'b1;
            state_d = rrs_pkg::ST_READ;
          end
        end
      end
      rrs_pkg::ST_READ: begin
        // Pointers already reflect the pop; the write back uses the tail.
        state_d      = rrs_pkg::ST_IDLE;
        res_valid    = 1'b1;
        res.served_id = ram_rdata.id;
        res.run_time = run_sat;
        res.finished = done;
        ram_wdata    = '{id: ram_rdata.id, need: ram_rdata.need, run: run_sat};
        if (!done) begin
          ram_we          = 1'b1;
          tail_d          = next_pos(tail_q);
          count_d         = count_q + 1'b1;
          res.queue_count = rrs_pkg::QCNT_W'(count_q + 1'b1);
        end
      end
      default: begin
        state_d = rrs_pkg::ST_IDLE;
      end
    endcase
  end

  // Ready queue storage; the head is read at every edge.
  rrs_ram #(
    .WIDTH(rrs_pkg::SLOT_W),
    .DEPTH(rrs_pkg::QUEUE_DEPTH)
  ) u_ready_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // Output register and skid stage.
  rrs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_res),
    .skid_full_o (skid_full)
  );

  assign served_id_o   = out_res.served_id;
  assign run_time_o    = out_res.run_time;
  assign finished_o    = out_res.finished;
  assign status_o      = out_res.status;
  assign queue_count_o = out_res.queue_count;

endmodule
`default_nettype wire

// ----- src/rrs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module rrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- src/rrs_out_buf.sv -----
// Output register with a one-entry skid stage for result transactions.
`default_nettype none
module rrs_out_buf (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            res_valid_i,
  input  wire rrs_pkg::result_t res_i,
  input  wire logic            out_stall_i,
  output logic                 out_valid_o,
  output rrs_pkg::result_t     out_o,
  output logic                 skid_full_o
);

  logic             out_valid_q;
  rrs_pkg::result_t out_q;
  logic             skid_valid_q;
  rrs_pkg::result_t skid_q;
  logic             out_free;

  // The output register can take a new result when empty or draining.
  assign out_free = !out_valid_q || !out_stall_i;

  // Control: valid flags of the output register and the skid stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      priority if (out_free && skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= res_valid_i;
      end else if (out_free) begin
        out_valid_q  <= res_valid_i;
      end else if (res_valid_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        // Stalled with no new result: both flags hold.
      end
    end
  end

  // Payload: results enter in order, the skid stage always drains first.
  always_ff @(posedge clk_i) begin
    priority if (out_free && skid_valid_q) begin
      out_q <= skid_q;
      if (res_valid_i) begin
        skid_q <= res_i;
      end
    end else if (out_free) begin
      if (res_valid_i) begin
        out_q <= res_i;
      end
    end else if (res_valid_i) begin
      skid_q <= res_i;
    end else begin
      // Stalled with no new result: both stages hold.
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign skid_full_o = skid_valid_q;

endmodule
`default_nettype wire
